// ----- sv/kfrh_pkg.sv -----
// shared types, constants and hash step functions for the k-mer hash block
// no dependencies; imported by kfrh_hash_pipe, kmer_forward_reverse_hash and the testbench
package kfrh_pkg;

    typedef logic [63:0] hash_word_t;

    // forward and reverse-complement words traveling together
    typedef struct packed {
        hash_word_t fwd;
        hash_word_t rev;
    } kmer_pair_t;

    // decoded nucleotide: ok low means ambiguous character
    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } base_code_t;

    localparam int KLEN_W = 6;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd15;

    // register index (byte address bit 2)
    localparam logic REG_KMER_LENGTH = 1'b0;

    // mixing shift amounts
    localparam int SH_A  = 21;
    localparam int SH_B  = 24;
    localparam int SH_C0 = 3;
    localparam int SH_C1 = 8;
    localparam int SH_D  = 14;
    localparam int SH_E0 = 2;
    localparam int SH_E1 = 4;
    localparam int SH_F  = 28;
    localparam int SH_G  = 31;

    // ascii byte to 2-bit nucleotide code
    function automatic base_code_t base_code(input logic [7:0] ch);
        base_code_t r;
        r.ok   = 1'b1;
        r.code = 2'd0;
        unique case (ch)
            8'h00, 8'h41, 8'h61: r.code = 2'd0;  // A a
            8'h01, 8'h43, 8'h63: r.code = 2'd1;  // C c
            8'h02, 8'h47, 8'h67: r.code = 2'd2;  // G g
            8'h03, 8'h54, 8'h74: r.code = 2'd3;  // T t
            default:             r.ok   = 1'b0;
        endcase
        return r;
    endfunction

    // low 2k bits set; k of 32 gives all ones
    function automatic hash_word_t kmer_mask(input logic [KLEN_W-1:0] k);
        hash_word_t m;
        for (int i = 0; i < 64; i++) begin
            m[i] = (7'(i) < {k, 1'b0});
        end
        return m;
    endfunction

    // first step: mask, add with inverted key, fold down
    function automatic hash_word_t mix_a(input hash_word_t key, input hash_word_t mask);
        hash_word_t k0;
        hash_word_t k1;
        k0 = key & mask;
        k1 = (~k0 + (k0 << SH_A)) & mask;
        return k1 ^ (k1 >> SH_B);
    endfunction

    // times 265, fold down
    function automatic hash_word_t mix_b(input hash_word_t key, input hash_word_t mask);
        hash_word_t k1;
        k1 = (key + (key << SH_C0) + (key << SH_C1)) & mask;
        return k1 ^ (k1 >> SH_D);
    endfunction

    // times 21, fold down
    function automatic hash_word_t mix_c(input hash_word_t key, input hash_word_t mask);
        hash_word_t k1;
        k1 = (key + (key << SH_E0) + (key << SH_E1)) & mask;
        return k1 ^ (k1 >> SH_F);
    endfunction

    // final add
    function automatic hash_word_t mix_d(input hash_word_t key, input hash_word_t mask);
        return (key + (key << SH_G)) & mask;
    endfunction

endpackage

// ----- sv/kfrh_hash_pipe.sv -----
// pipelined masked mixing hash over a forward / reverse word pair
// depends on kfrh_pkg; instantiated by kmer_forward_reverse_hash
module kfrh_hash_pipe (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  kfrh_pkg::kmer_pair_t in_pair,
    input  kfrh_pkg::hash_word_t mask,
    output logic                out_valid,
    input  logic                out_ready,
    output kfrh_pkg::kmer_pair_t out_pair
);
    import kfrh_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG-1:0] en;

    kmer_pair_t s0_reg;
    kmer_pair_t s1_reg;
    kmer_pair_t s2_reg;
    kmer_pair_t s3_reg;
    kmer_pair_t s4_reg;

    // stage advance: a stage moves when empty or when the next one moves
    always_comb begin
        en[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_comb begin
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NSTG; i++) begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // data stages: the input stage, then one mixing step each
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s0_reg <= in_pair;
        end
        if (en[1]) begin
            s1_reg.fwd <= mix_a(s0_reg.fwd, mask);
            s1_reg.rev <= mix_a(s0_reg.rev, mask);
        end
        if (en[2]) begin
            s2_reg.fwd <= mix_b(s1_reg.fwd, mask);
            s2_reg.rev <= mix_b(s1_reg.rev, mask);
        end
        if (en[3]) begin
            s3_reg.fwd <= mix_c(s2_reg.fwd, mask);
            s3_reg.rev <= mix_c(s2_reg.rev, mask);
        end
        if (en[4]) begin
            s4_reg.fwd <= mix_d(s3_reg.fwd, mask);
            s4_reg.rev <= mix_d(s3_reg.rev, mask);
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];
    assign out_pair  = s4_reg;

    // a taken request shows up in the first stage
    a_load_first: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> v_reg[0])
        else $error("accepted request missing from first stage");

    // input blocks only when every stage is full and the output stalls
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (v_reg == {NSTG{1'b1}}) && !out_ready)
        else $error("input stalled with room in pipeline");

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(s4_reg))
        else $error("stalled result changed");

    // a stage that cannot move keeps its item
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[NSTG-2] && !en[NSTG-1] |=> v_reg[NSTG-2] && $stable(s3_reg))
        else $error("blocked stage lost its item");

endmodule

// ----- sv/kmer_forward_reverse_hash.sv -----
// top level: k-mer forward / reverse-complement hash with apb length register
// depends on kfrh_pkg and kfrh_hash_pipe
//
// One nucleotide character is taken per clock while s_ready is high. A/C/G/T in either case (and
// bytes 0..3) shift a 2-bit code into the forward k-mer and its complement
// into the reverse-complement k-mer; other bytes are skipped. On a character
// marked last, both k-mers are hashed with the masked 64-bit integer mix and
// one result carrying both hashes is offered once it has passed the input
// stage and the four mixing stages; the k-mers clear once that character is taken.
// A new character is accepted every cycle as long as the result side drains; the
// five register stages are the input stage and four mixing stages, each holding
// one shift-add step, all but the last with its fold.
// kmer_length (byte address 0) sets k from its low 6 bits; 0 acts as 1 and values above
// MAX_KMER_LENGTH act as MAX_KMER_LENGTH. Write it only while idle.
module kmer_forward_reverse_hash #(
    parameter int MAX_KMER_LENGTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [7:0]                    s_base_char,
    input  logic                          s_last,
    input  logic                          s_valid,
    output logic                          s_ready,
    output logic [63:0]                   m_forward_hash,
    output logic [63:0]                   m_reverse_hash,
    output logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kfrh_pkg::ADDR_W-1:0]   paddr,
    input  logic [kfrh_pkg::DATA_W-1:0]   pwdata,
    output logic [kfrh_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import kfrh_pkg::*;

    localparam int KW = 2 * MAX_KMER_LENGTH;
    localparam logic [KLEN_W-1:0] MAX_K = KLEN_W'(MAX_KMER_LENGTH);
    localparam logic [KLEN_W-1:0] KEFF_RESET = (KLEN_RESET > MAX_K) ? MAX_K : KLEN_RESET;

    logic [KLEN_W-1:0] klen_reg;
    logic [KLEN_W-1:0] keff_reg;
    logic [KLEN_W-1:0] keff_next;
    logic              cfg_wr;

    logic [KW-1:0]     fwd_reg;
    logic [KW-1:0]     rev_reg;
    logic [KW-1:0]     fwd_next;
    logic [KW-1:0]     rev_next;
    logic [KW-1:0]     fwd_upd;
    logic [KW-1:0]     rev_upd;

    hash_word_t        mask_full;
    logic [KW-1:0]     mask;
    logic [KLEN_W-1:0] ins_shift;
    base_code_t        bc;
    logic              s_take;

    kmer_pair_t        pipe_in;
    kmer_pair_t        pipe_out;
    logic              pipe_in_ready;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_KMER_LENGTH);

    always_comb begin
        if (pwdata[KLEN_W-1:0] == '0) begin
            keff_next = KLEN_W'(1);
        end else if (pwdata[KLEN_W-1:0] > MAX_K) begin
            keff_next = MAX_K;
        end else begin
            keff_next = pwdata[KLEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            klen_reg <= KLEN_RESET;
            keff_reg <= KEFF_RESET;
        end else if (cfg_wr) begin
            klen_reg <= pwdata[KLEN_W-1:0];
            keff_reg <= keff_next;
        end
    end

    assign prdata = (paddr[2] == REG_KMER_LENGTH) ? DATA_W'(klen_reg) : '0;

    // mask and reverse insert position from effective k
    assign mask_full = kmer_mask(keff_reg);
    assign mask      = mask_full[KW-1:0];
    assign ins_shift = KLEN_W'((keff_reg - KLEN_W'(1)) << 1);

    // character decode and k-mer shift
    assign bc     = base_code(s_base_char);
    assign s_take = s_valid && s_ready;

    always_comb begin
        if (bc.ok) begin
            fwd_upd = ((fwd_reg << 2) | KW'(bc.code)) & mask;
            rev_upd = ((rev_reg >> 2) | (KW'(2'b11 ^ bc.code) << ins_shift)) & mask;
        end else begin
            fwd_upd = fwd_reg;
            rev_upd = rev_reg;
        end
    end

    always_comb begin
        fwd_next = fwd_reg;
        rev_next = rev_reg;
        if (s_take) begin
            if (s_last) begin
                fwd_next = '0;
                rev_next = '0;
            end else begin
                fwd_next = fwd_upd;
                rev_next = rev_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= '0;
            rev_reg <= '0;
        end else begin
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
        end
    end

    // hash pipeline, loaded by the last character of a string
    assign pipe_in.fwd = 64'(fwd_upd);
    assign pipe_in.rev = 64'(rev_upd);

    kfrh_hash_pipe u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid && s_last),
        .in_ready  (pipe_in_ready),
        .in_pair   (pipe_in),
        .mask      (mask_full),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_pair  (pipe_out)
    );

    assign s_ready        = pipe_in_ready;
    assign m_forward_hash = pipe_out.fwd;
    assign m_reverse_hash = pipe_out.rev;

    // k-mers start over after the last character
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take && s_last |=> (fwd_reg == '0) && (rev_reg == '0))
        else $error("k-mers not cleared after last character");

    // an ambiguous character that is not last leaves the k-mers alone
    a_skip_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take && !s_last && !bc.ok |=> $stable(fwd_reg) && $stable(rev_reg))
        else $error("ambiguous character changed k-mers");

    // k-mers never grow past the current mask
    a_masked: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take && bc.ok |=> ((fwd_reg & ~mask) == '0) && ((rev_reg & ~mask) == '0))
        else $error("k-mer bits above 2k");

endmodule

// ----- tb/kmer_forward_reverse_hash_tb.sv -----
// self-checking testbench for kmer_forward_reverse_hash: character requests in, hash pairs out
// depends on kfrh_pkg and the kmer_forward_reverse_hash rtl; predicts both hashes in-bench
module kmer_forward_reverse_hash_tb;
    import kfrh_pkg::*;

    localparam int MAX_K         = 32;
    localparam int PIPE_LATENCY  = 5;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 80;
    localparam logic [ADDR_W-1:0] KLEN_ADDR = {REG_KMER_LENGTH, 2'b00};

    // every byte that decodes to a nucleotide
    localparam logic [7:0] NUC_BYTES [12] = '{
        8'h41, 8'h43, 8'h47, 8'h54, 8'h61, 8'h63, 8'h67, 8'h74,
        8'h00, 8'h01, 8'h02, 8'h03
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_req_t;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic [7:0]        s_base_char    = 8'h00;
    logic              s_last         = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [63:0]       m_forward_hash;
    logic [63:0]       m_reverse_hash;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [ADDR_W-1:0] paddr          = '0;
    logic [DATA_W-1:0] pwdata         = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    char_req_t  pending_chars[$];
    kmer_pair_t expected_hashes[$];

    // predictor state
    logic [KLEN_W-1:0] klen_reg = KLEN_RESET;
    hash_word_t        fwd_kmer = '0;
    hash_word_t        rc_kmer  = '0;

    int idle_pct      = 31;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int errors        = 0;
    int quiet_cycles  = 0;

    kmer_forward_reverse_hash #(.MAX_KMER_LENGTH(MAX_K)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_base_char    (s_base_char),
        .s_last         (s_last),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .m_forward_hash (m_forward_hash),
        .m_reverse_hash (m_reverse_hash),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 aclk = ~aclk;

    // nucleotide decode; ok low marks an ambiguous byte
    function automatic base_code_t classify_char(input logic [7:0] ch);
        base_code_t r;
        r.ok   = 1'b1;
        r.code = 2'd0;
        case (ch)
            8'h00, 8'h41, 8'h61: r.code = 2'd0;
            8'h01, 8'h43, 8'h63: r.code = 2'd1;
            8'h02, 8'h47, 8'h67: r.code = 2'd2;
            8'h03, 8'h54, 8'h74: r.code = 2'd3;
            default:             r.ok   = 1'b0;
        endcase
        return r;
    endfunction

    // zero acts as one, anything above the maximum is clamped
    function automatic int effective_k(input logic [KLEN_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_K) return MAX_K;
        return int'(v);
    endfunction

    function automatic hash_word_t low_bits_mask(input int k);
        if (k >= 32) return '1;
        return (64'd1 << (2 * k)) - 64'd1;
    endfunction

    // masked integer mixing hash
    function automatic hash_word_t scramble(input hash_word_t key, input hash_word_t mask);
        hash_word_t x;
        x = key & mask;
        x = (~x + (x << 21)) & mask;
        x = x ^ (x >> 24);
        x = (x + (x << 3) + (x << 8)) & mask;
        x = x ^ (x >> 14);
        x = (x + (x << 2) + (x << 4)) & mask;
        x = x ^ (x >> 28);
        x = (x + (x << 31)) & mask;
        return x;
    endfunction

    // update the k-mer pair for one accepted request, queue hashes on last
    function automatic void take_char(input char_req_t r);
        int         k;
        hash_word_t mask;
        base_code_t bc;
        kmer_pair_t p;
        k    = effective_k(klen_reg);
        mask = low_bits_mask(k);
        bc   = classify_char(r.ch);
        if (bc.ok) begin
            fwd_kmer = ((fwd_kmer << 2) | 64'(bc.code)) & mask;
            rc_kmer  = ((rc_kmer >> 2) | (64'(2'd3 ^ bc.code) << (2 * (k - 1)))) & mask;
        end
        if (r.last) begin
            p.fwd = scramble(fwd_kmer, mask);
            p.rev = scramble(rc_kmer, mask);
            expected_hashes.push_back(p);
            fwd_kmer = '0;
            rc_kmer  = '0;
        end
    endfunction

    // request driver
    always @(posedge aclk) begin : char_driver
        char_req_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                take_char('{ch: s_base_char, last: s_last});
            end
            if (!s_valid || s_ready) begin
                if (pending_chars.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    r = pending_chars.pop_front();
                    s_base_char <= r.ch;
                    s_last      <= r.last;
                    s_valid     <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin : hash_monitor
        kmer_pair_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_hashes.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual fwd %h rev %h",
                             $time, m_forward_hash, m_reverse_hash);
                    errors++;
                end else begin
                    want = expected_hashes.pop_front();
                    if (m_forward_hash !== want.fwd) begin
                        $display("%0t: forward_hash mismatch: expected %h, actual %h",
                                 $time, want.fwd, m_forward_hash);
                        errors++;
                    end
                    if (m_reverse_hash !== want.rev) begin
                        $display("%0t: reverse_hash mismatch: expected %h, actual %h",
                                 $time, want.rev, m_reverse_hash);
                        errors++;
                    end
                end
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** kmer_forward_reverse_hash: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_char(input logic [7:0] ch, input logic last);
        pending_chars.push_back('{ch: ch, last: last});
    endtask

    function automatic logic [7:0] random_base();
        return NUC_BYTES[$urandom_range(0, 11)];
    endfunction

    function automatic logic [7:0] random_ambiguous();
        logic [7:0] b;
        base_code_t bc;
        b  = 8'($urandom_range(0, 255));
        bc = classify_char(b);
        while (bc.ok) begin
            b  = 8'($urandom_range(0, 255));
            bc = classify_char(b);
        end
        return b;
    endfunction

    // wait until every request is taken and every result seen, then let the pipe settle
    task automatic drain();
        while (pending_chars.size() != 0 || s_valid || expected_hashes.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 3) @(posedge aclk);
    endtask

    // apb write: setup then access cycle
    task automatic write_kmer_length(input logic [KLEN_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KLEN_ADDR;
        pwdata  <= {26'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        klen_reg = val;
    endtask

    // mostly well-formed k-mers with random content, some noise
    task automatic random_phase(input logic [KLEN_W-1:0] klen, input int budget,
                                input bit with_hold);
        int counted;
        int results;
        int len;
        int r;
        int k;
        int lo;
        logic [7:0] ch;
        logic last;
        base_code_t bc;
        counted = 0;
        results = 0;
        drain();
        write_kmer_length(klen);
        k = effective_k(klen);
        // receiver holds off while one-base k-mers keep coming
        if (with_hold) begin
            hold_requests++;
            repeat (40) push_char(random_base(), 1'b1);
        end
        while (counted < budget || results < 8) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                ch   = 8'($urandom_range(0, 255));
                last = 1'($urandom_range(0, 1));
                push_char(ch, last);
                bc = classify_char(ch);
                if (bc.ok || last) counted++;
                if (last) results++;
            end else begin
                lo = (k > 2) ? k - 2 : 1;
                if (r < 35) len = $urandom_range(1, 4);
                else if (r < 85) len = $urandom_range(lo, k + 2);
                else len = $urandom_range(1, 40);
                for (int i = 0; i < len; i++) begin
                    last = (i == len - 1);
                    ch = ($urandom_range(0, 99) < 8) ? random_ambiguous() : random_base();
                    push_char(ch, last);
                    bc = classify_char(ch);
                    if (bc.ok || last) counted++;
                end
                results++;
            end
        end
    endtask

    // stimulus and end of run
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset length, both cases, raw codes, ambiguous last
        push_char(8'h41, 1'b0); push_char(8'h43, 1'b0);
        push_char(8'h47, 1'b0); push_char(8'h54, 1'b1);
        push_char(8'h61, 1'b0); push_char(8'h63, 1'b0); push_char(8'h67, 1'b0);
        push_char(8'h74, 1'b0); push_char(8'h4E, 1'b1);
        push_char(8'h00, 1'b0); push_char(8'h01, 1'b0);
        push_char(8'h02, 1'b0); push_char(8'h03, 1'b1);
        push_char(8'hFF, 1'b1);
        // partial k-mer left in the registers across a length change
        push_char(8'h47, 1'b0); push_char(8'h54, 1'b0); push_char(8'h43, 1'b0);
        drain();
        write_kmer_length(6'd1);
        push_char(8'h41, 1'b0); push_char(8'h74, 1'b1);

        // random phases over several lengths, the first without idling
        idle_pct = 0;
        random_phase(6'd32, 180, 1'b0);
        idle_pct = 31;
        random_phase(6'd0, 120, 1'b0);
        random_phase(6'd63, 150, 1'b0);
        random_phase(6'd7, 140, 1'b1);
        random_phase(6'($urandom_range(1, 32)), 140, 1'b0);
        random_phase(6'd40, 120, 1'b0);
        random_phase(6'd2, 120, 1'b0);
        random_phase(6'd15, 120, 1'b0);

        drain();
        repeat (PIPE_LATENCY + 5) @(posedge aclk);
        if (errors == 0 && expected_hashes.size() == 0) begin
            $display("** kmer_forward_reverse_hash: PASSED **");
        end else begin
            $display("** kmer_forward_reverse_hash: FAILED **");
        end
        $finish;
    end

endmodule
